/* rtl/core/brfs_pkg.sv */
// Shared types and constants for the byte ring FIFO with skip.
package brfs_pkg;

    localparam int unsigned MAX_SLOTS_DEF = 4096;
    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned CNT_W         = 12;
    localparam int unsigned RSIZE_W       = 13;
    localparam int unsigned MODE_W        = 3;
    localparam int unsigned S_TDATA_W     = 24;
    localparam int unsigned M_TDATA_W     = 72;
    localparam int unsigned PADDR_W       = 3;
    localparam int unsigned PDATA_W       = 32;

    localparam logic [RSIZE_W-1:0] RING_SIZE_RST = RSIZE_W'(4096);

    // register index (byte address / 4)
    localparam logic [0:0] REG_RING_SIZE = 1'b0;

    typedef enum logic [MODE_W-1:0] {
        MODE_WRITE  = 3'd0,
        MODE_READ   = 3'd1,
        MODE_SKIP   = 3'd2,
        MODE_RESET  = 3'd3,
        MODE_STATUS = 3'd4
    } t_mode;

endpackage

/* rtl/core/brfs_store.sv */
// Byte storage RAM: one write port, one read port, registered read data.
module brfs_store #(
    parameter int unsigned DEPTH = brfs_pkg::MAX_SLOTS_DEF,
    parameter int unsigned AW    = $clog2(brfs_pkg::MAX_SLOTS_DEF)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [brfs_pkg::BYTE_W-1:0] i_wdata,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_raddr,
    output logic [brfs_pkg::BYTE_W-1:0] o_rdata
);
    import brfs_pkg::*;

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while no new read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/byte_ring_fifo_with_skip_core.sv */
// Byte ring FIFO with skip: top level with pointers, operation decode and result stage.
//
// Usage: one operation per item on the slave stream (write a byte, read a byte,
// skip up to a count of bytes, reset the pointers, or status). Each item gives
// exactly one result item on the master stream with the byte read, a done flag,
// the bytes skipped, and fill level, free room, contiguous run and read
// position after the operation. One slot of the ring is always left empty.
// The accepting edge issues the byte RAM read into the read stage; the result
// register loads from the read stage once it is empty or its result is taken,
// and tvalid rises as it loads. Throughput: one item per cycle while the master
// side takes results; the pointers sit in flip-flops and the RAM is read once
// per item and written only for a write into a ring with room.
// When the receiver stalls, the result register and then the RAM read stage
// fill up and tready drops; nothing is lost. The ring_size register (APB,
// address 0) sets the slots in use, clamped to 2..MAX_SLOTS; writing it
// empties the ring. Reset empties the ring and sets ring_size to 4096; the
// RAM is not cleared and needs no clearing pass.
module byte_ring_fifo_with_skip_core #(
    parameter int unsigned MAX_SLOTS = brfs_pkg::MAX_SLOTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // slave stream
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // [2:0] mode, [10:3] write_byte, [22:11] skip_count, [23] zero
    input  logic [brfs_pkg::S_TDATA_W-1:0] i_s_tdata,
    // master stream
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [7:0] read_byte, [8] done_res, [20:9] skipped, [32:21] fill_level,
    // [44:33] free_room, [56:45] run_length, [68:57] read_position, [71:69] zero
    output logic [brfs_pkg::M_TDATA_W-1:0] o_m_tdata,
    // APB configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [brfs_pkg::PADDR_W-1:0]   paddr,
    input  logic [brfs_pkg::PDATA_W-1:0]   pwdata,
    output logic [brfs_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import brfs_pkg::*;

    localparam int unsigned PW = $clog2(MAX_SLOTS);
    localparam int unsigned SW = PW + 1;
    localparam int unsigned CW = (SW > CNT_W) ? SW : CNT_W;
    // reset ring size after clamping to the slots present
    localparam int unsigned SIZE_RST = (MAX_SLOTS < 32'(RING_SIZE_RST)) ? MAX_SLOTS
                                                                        : 32'(RING_SIZE_RST);

    // configuration
    logic               cfg_we;
    logic [RSIZE_W-1:0] r_ring_size;
    logic [SW-1:0]      r_size;      // clamped ring size
    logic [SW-1:0]      n_size;

    // pointers
    logic [PW-1:0] r_wp, r_rp, n_wp, n_rp;

    // item decode
    logic              s_acc;
    t_mode             mode;
    logic [BYTE_W-1:0] wbyte;
    logic [CNT_W-1:0]  scount;

    logic [SW-1:0] fill_cur, room_cur, run_cur;
    logic [SW-1:0] wp_inc, rp_inc, skipped, rp_sum;
    logic [PW-1:0] wp_adv, rp_adv, rp_skip;
    logic          wr_ok, rd_ok;

    // RAM read stage
    logic              r_s1_valid, r_s1_rd, r_s1_done;
    logic [CNT_W-1:0]  r_s1_skipped;
    logic              s1_go;
    logic [BYTE_W-1:0] mem_rdata;

    // result stage
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_o_byte;
    logic              r_o_done;
    logic [CNT_W-1:0]  r_o_skipped, r_o_fill, r_o_room, r_o_run, r_o_pos;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite & pready & (paddr[2] == REG_RING_SIZE);

    always_comb begin
        if (pwdata[RSIZE_W-1:0] < RSIZE_W'(2)) begin
            n_size = SW'(2);
        end else if (32'(pwdata[RSIZE_W-1:0]) > 32'(MAX_SLOTS)) begin
            n_size = SW'(MAX_SLOTS);
        end else begin
            n_size = SW'(pwdata[RSIZE_W-1:0]);
        end
    end

    always_comb begin
        if (paddr[2] == REG_RING_SIZE) begin
            prdata = PDATA_W'(r_ring_size);
        end else begin
            prdata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_size <= RING_SIZE_RST;
            r_size      <= SW'(SIZE_RST);
        end else if (cfg_we) begin
            r_ring_size <= pwdata[RSIZE_W-1:0];
            r_size      <= n_size;
        end
    end

    // ---------------- operation decode ----------------
    assign s_acc  = i_s_tvalid & o_s_tready;
    assign mode   = t_mode'(i_s_tdata[MODE_W-1:0]);
    assign wbyte  = i_s_tdata[MODE_W +: BYTE_W];
    assign scount = i_s_tdata[MODE_W+BYTE_W +: CNT_W];

    // state as held in the pointers; also the post-operation view for the
    // item sitting in the read stage
    assign fill_cur = (r_wp >= r_rp) ? (SW'(r_wp) - SW'(r_rp))
                                     : (r_size - SW'(r_rp) + SW'(r_wp));
    assign room_cur = r_size - fill_cur - SW'(1);
    assign run_cur  = (r_wp >= r_rp) ? (SW'(r_wp) - SW'(r_rp)) : (r_size - SW'(r_rp));

    assign wr_ok = (room_cur != '0);
    assign rd_ok = (fill_cur != '0);

    assign wp_inc = SW'(r_wp) + SW'(1);
    assign rp_inc = SW'(r_rp) + SW'(1);
    assign wp_adv = (wp_inc >= r_size) ? '0 : wp_inc[PW-1:0];
    assign rp_adv = (rp_inc >= r_size) ? '0 : rp_inc[PW-1:0];

    // skip clamps to the fill level; sum stays below twice the size
    assign skipped = (CW'(scount) > CW'(fill_cur)) ? fill_cur : SW'(scount);
    assign rp_sum  = SW'(r_rp) + skipped;
    assign rp_skip = (rp_sum >= r_size) ? PW'(rp_sum - r_size) : rp_sum[PW-1:0];

    always_comb begin
        n_wp = r_wp;
        n_rp = r_rp;
        if (s_acc) begin
            unique case (mode)
                MODE_WRITE: begin
                    if (wr_ok) begin
                        n_wp = wp_adv;
                    end
                end
                MODE_READ: begin
                    if (rd_ok) begin
                        n_rp = rp_adv;
                    end
                end
                MODE_SKIP: begin
                    n_rp = rp_skip;
                end
                MODE_RESET: begin
                    n_wp = '0;
                    n_rp = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else if (cfg_we) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            r_wp <= n_wp;
            r_rp <= n_rp;
        end
    end

    // ---------------- byte RAM ----------------
    brfs_store #(
        .DEPTH (MAX_SLOTS),
        .AW    (PW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (s_acc && mode == MODE_WRITE && wr_ok),
        .i_waddr (r_wp),
        .i_wdata (wbyte),
        .i_re    (s_acc),
        .i_raddr (r_rp),
        .o_rdata (mem_rdata)
    );

    // ---------------- read stage ----------------
    assign s1_go      = r_s1_valid & (~r_out_valid | i_m_tready);
    assign o_s_tready = ~r_s1_valid | s1_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1_rd      <= (mode == MODE_READ) && rd_ok;
            r_s1_done    <= ((mode == MODE_READ) && rd_ok) || ((mode == MODE_WRITE) && wr_ok);
            r_s1_skipped <= (mode == MODE_SKIP) ? CNT_W'(skipped) : '0;
        end
    end

    // ---------------- result stage ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // pointers hold the state left by the item in the read stage here
    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_o_byte    <= r_s1_rd ? mem_rdata : '0;
            r_o_done    <= r_s1_done;
            r_o_skipped <= r_s1_skipped;
            r_o_fill    <= CNT_W'(fill_cur);
            r_o_room    <= CNT_W'(room_cur);
            r_o_run     <= CNT_W'(run_cur);
            r_o_pos     <= CNT_W'(r_rp);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_o_pos, r_o_run, r_o_room, r_o_fill,
                         r_o_skipped, r_o_done, r_o_byte};

`ifndef SYNTHESIS
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (SW'(r_wp) < r_size) && (SW'(r_rp) < r_size))
        else $error("ring pointer beyond ring size");

    a_full_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && mode == MODE_WRITE && !wr_ok && !cfg_we |=> $stable(r_wp) && $stable(r_rp))
        else $error("write into full ring moved a pointer");

    a_empty_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && mode == MODE_READ && !rd_ok && !cfg_we |=> $stable(r_rp) && !r_s1_done)
        else $error("read from empty ring took a byte");

    a_stage_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go |=> r_out_valid)
        else $error("item left read stage without reaching result register");
`endif

endmodule

/* dv/tb.sv */
// Testbench for byte_ring_fifo_with_skip_core: directed and random ring operations.
`timescale 1ns / 100ps

class ring_status_board;
    typedef struct {
        logic [7:0]  read_byte;
        logic        done_res;
        logic [11:0] skipped;
        logic [11:0] fill_level;
        logic [11:0] free_room;
        logic [11:0] run_length;
        logic [11:0] read_position;
    } t_status;

    logic [7:0]  store [brfs_pkg::MAX_SLOTS_DEF];
    int unsigned wr_ptr   = 0;
    int unsigned rd_ptr   = 0;
    logic [12:0] size_reg = brfs_pkg::RING_SIZE_RST;
    t_status     status_q [$];
    int          errors   = 0;

    // slots in use after clamping the register to 2..MAX_SLOTS
    function int unsigned slots();
        if (size_reg < 2) return 2;
        if (size_reg > brfs_pkg::MAX_SLOTS_DEF) return brfs_pkg::MAX_SLOTS_DEF;
        return size_reg;
    endfunction

    function int unsigned level();
        if (wr_ptr >= rd_ptr) return wr_ptr - rd_ptr;
        return slots() - rd_ptr + wr_ptr;
    endfunction

    function int unsigned step_ptr(int unsigned p, int unsigned n);
        int unsigned q;
        q = p + n;
        if (q >= slots()) q -= slots();
        return q;
    endfunction

    function void set_ring_size(logic [12:0] value);
        size_reg = value;
        wr_ptr   = 0;
        rd_ptr   = 0;
    endfunction

    // apply one accepted item and queue the status it must produce
    function void apply_op(logic [2:0] mode, logic [7:0] wbyte, logic [11:0] cnt);
        int unsigned n;
        int unsigned fill;
        int unsigned k;
        t_status     st;
        n    = slots();
        fill = level();
        st   = '{default: '0};
        case (mode)
            brfs_pkg::MODE_WRITE: begin
                if (n - fill - 1 != 0) begin
                    store[wr_ptr] = wbyte;
                    wr_ptr        = step_ptr(wr_ptr, 1);
                    st.done_res   = 1'b1;
                end
            end
            brfs_pkg::MODE_READ: begin
                if (fill != 0) begin
                    st.read_byte = store[rd_ptr];
                    rd_ptr       = step_ptr(rd_ptr, 1);
                    st.done_res  = 1'b1;
                end
            end
            brfs_pkg::MODE_SKIP: begin
                k          = (cnt > fill) ? fill : cnt;
                st.skipped = 12'(k);
                rd_ptr     = step_ptr(rd_ptr, k);
            end
            brfs_pkg::MODE_RESET: begin
                wr_ptr = 0;
                rd_ptr = 0;
            end
            default: ;  // status and spare codes change nothing
        endcase
        fill             = level();
        st.fill_level    = 12'(fill);
        st.free_room     = 12'(n - fill - 1);
        st.run_length    = 12'((wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : n - rd_ptr);
        st.read_position = 12'(rd_ptr);
        status_q.push_back(st);
    endfunction

    task report(string field, longint unsigned got, longint unsigned want_v);
        $display("mismatch %s: got %0h, expected %0h", field, got, want_v);
        errors++;
    endtask

    task check_status(logic [brfs_pkg::M_TDATA_W-1:0] d);
        t_status want;
        if (status_q.size() == 0) begin
            report("result with no item pending", d[63:0], 0);
            return;
        end
        want = status_q.pop_front();
        if (d[7:0] !== want.read_byte) report("read_byte", d[7:0], want.read_byte);
        if (d[8] !== want.done_res) report("done_res", d[8], want.done_res);
        if (d[20:9] !== want.skipped) report("skipped", d[20:9], want.skipped);
        if (d[32:21] !== want.fill_level) report("fill_level", d[32:21], want.fill_level);
        if (d[44:33] !== want.free_room) report("free_room", d[44:33], want.free_room);
        if (d[56:45] !== want.run_length) report("run_length", d[56:45], want.run_length);
        if (d[68:57] !== want.read_position) begin
            report("read_position", d[68:57], want.read_position);
        end
    endtask
endclass

module tb;
    import brfs_pkg::*;

    localparam int unsigned          IDLE_LIMIT     = 1000;
    localparam logic [PADDR_W-1:0]   RING_SIZE_ADDR = PADDR_W'(REG_RING_SIZE) << 2;
    localparam logic [MODE_W-1:0]    MODE_SPARE_LO  = MODE_W'(MODE_STATUS + 1);
    localparam logic [MODE_W-1:0]    MODE_SPARE_HI  = '1;

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    // [2:0] mode, [10:3] write_byte, [22:11] skip_count, [23] zero
    logic [S_TDATA_W-1:0]   i_s_tdata  = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    // [7:0] read_byte, [8] done_res, [20:9] skipped, [32:21] fill_level,
    // [44:33] free_room, [56:45] run_length, [68:57] read_position, [71:69] zero
    logic [M_TDATA_W-1:0]   o_m_tdata;
    logic                   psel       = 1'b0;
    logic                   penable    = 1'b0;
    logic                   pwrite     = 1'b0;
    logic [PADDR_W-1:0]     paddr      = '0;
    logic [PDATA_W-1:0]     pwdata     = '0;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    ring_status_board board = new();
    bit                     tx_idle      = 1'b1;
    bit                     rx_idle      = 1'b1;
    int unsigned            hold_cycles  = 0;
    int unsigned            quiet_cycles = 0;

    byte_ring_fifo_with_skip_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (o_m_tvalid && i_m_tready) board.check_status(o_m_tdata);
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("tb failed");
                $finish;
            end
        end
    end

    // result side: random stalls per item, plus an optional long hold
    initial begin
        int unsigned stall;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_cycles > 0) begin
                i_m_tready <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
            end
            stall = rx_idle ? $urandom_range(0, 3) : 0;
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    task automatic send_op(input logic [MODE_W-1:0] mode, input logic [7:0] wbyte,
                           input logic [11:0] cnt);
        int unsigned gap;
        gap = tx_idle ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {1'b0, cnt, wbyte, mode};
        do @(posedge i_clk); while (!o_s_tready);
        board.apply_op(mode, wbyte, cnt);
    endtask

    // stop offering items and let every pending status come back
    task automatic wait_drain();
        i_s_tvalid <= 1'b0;
        while (board.status_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic read_back(input logic [RSIZE_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= RING_SIZE_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[RSIZE_W-1:0] !== value) board.report("ring_size readback", prdata, value);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_ring_size(input logic [RSIZE_W-1:0] value);
        wait_drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= RING_SIZE_ADDR;
        // upper bits are noise, the register keeps only its own width
        pwdata  <= ($urandom() << RSIZE_W) | PDATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        board.set_ring_size(value);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        psel    <= 1'b0;
        @(posedge i_clk);
        read_back(value);
    endtask

    task automatic random_op(input int unsigned write_pct);
        int unsigned r;
        logic [11:0] cnt;
        logic [7:0]  wbyte;
        r     = $urandom_range(0, 99);
        wbyte = 8'($urandom());
        // mostly counts near the fill level, some anywhere in range
        cnt   = ($urandom_range(0, 3) == 0) ? 12'($urandom())
                                            : 12'($urandom_range(0, board.level() + 2));
        if (r < write_pct) send_op(MODE_WRITE, wbyte, cnt);
        else if (r < 86) send_op(MODE_READ, wbyte, cnt);
        else if (r < 92) send_op(MODE_SKIP, wbyte, cnt);
        else if (r < 94) send_op(MODE_RESET, wbyte, cnt);
        else if (r < 97) send_op(MODE_STATUS, wbyte, cnt);
        else send_op(MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI)), wbyte, cnt);
    endtask

    initial begin
        logic [RSIZE_W-1:0] ring_plan [10];
        int unsigned        write_pct;
        ring_plan    = '{3, 5, 16, 0, 1, 64, 4096, 8191, 4097, 9};
        ring_plan[9] = $urandom_range(2, 300);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        read_back(RING_SIZE_RST);

        // full-size ring after reset
        send_op(MODE_STATUS, 8'h00, 12'h000);
        send_op(MODE_WRITE, 8'h00, 12'hFFF);
        send_op(MODE_WRITE, 8'hFF, 12'h000);
        send_op(MODE_WRITE, 8'hA5, 12'h5A5);
        send_op(MODE_READ, 8'h5A, 12'hA5A);
        send_op(MODE_SKIP, 8'h3C, 12'h001);
        send_op(MODE_SKIP, 8'hC3, 12'hFFF);     // clamped to what is held
        send_op(MODE_READ, 8'hFF, 12'hFFF);     // empty
        send_op(MODE_WRITE, 8'h11, 12'h000);
        send_op(MODE_RESET, 8'h00, 12'h000);
        send_op(MODE_SPARE_LO, 8'hFF, 12'hFFF);
        send_op(MODE_W'(MODE_SPARE_LO + 1), 8'h00, 12'h000);
        send_op(MODE_SPARE_HI, 8'h81, 12'h801);

        // smallest ring holds a single byte
        write_ring_size(2);
        send_op(MODE_WRITE, 8'h5A, 12'h000);
        send_op(MODE_WRITE, 8'hC3, 12'h000);    // full, dropped
        send_op(MODE_READ, 8'h00, 12'h000);
        send_op(MODE_READ, 8'h00, 12'h000);     // empty
        send_op(MODE_WRITE, 8'h7E, 12'h000);
        send_op(MODE_SKIP, 8'h00, 12'hFFF);
        send_op(MODE_WRITE, 8'h01, 12'h000);
        send_op(MODE_READ, 8'h00, 12'h000);
        send_op(MODE_SKIP, 8'h00, 12'h000);
        send_op(MODE_STATUS, 8'h00, 12'h000);

        foreach (ring_plan[p]) begin
            write_ring_size(ring_plan[p]);
            tx_idle = (p % 3) != 1;
            rx_idle = (p % 4) != 2;
            if (p == 3) hold_cycles = 60;       // long output stall, input must back up
            write_pct = $urandom_range(30, 70);
            for (int i = 0; i < 65; i++) begin
                if (p == 5 && i == 30) wait_drain();
                if (i % 16 == 0) write_pct = $urandom_range(25, 75);
                random_op(write_pct);
            end
        end

        wait_drain();
        repeat (8) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule

/* filelist.f */
rtl/core/brfs_pkg.sv
rtl/core/brfs_store.sv
rtl/core/byte_ring_fifo_with_skip_core.sv
dv/tb.sv
